/* src/wads_pkg.sv */
// Shared types and constants for the windowed average deadband stepper.
package wads_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int LIMIT_BITS   = 12;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [LIMIT_BITS-1:0] INNER_RESET = 12'd10;
  localparam logic [LIMIT_BITS-1:0] OUTER_RESET = 12'd15;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_INNER = 2'd0,
    CFG_X_OUTER = 2'd1,
    CFG_Y_INNER = 2'd2,
    CFG_Y_OUTER = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ZONE_INNER = 2'd0,
    ZONE_BAND  = 2'd1,
    ZONE_OUTER = 2'd2
  } zone_t;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_DEC  = 2'd1,
    MOVE_INC  = 2'd2
  } move_t;

  // Per-transaction control carried from the sum stage into the output stage
  typedef struct packed {
    logic  x_neg;
    logic  y_neg;
    zone_t x_zone;
    zone_t y_zone;
    move_t x_move;
    move_t y_move;
  } side_t;

endpackage

/* src/wads_window_cell.sv */
// One window cell: holds an X and a Y sample and passes them to its neighbor.
module wads_window_cell #(
  parameter int SAMPLE_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic                          zero,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] y_i,
  output logic signed [SAMPLE_BITS-1:0] x_o,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (zero) begin
      x_r <= '0;
      y_r <= '0;
    end else if (load) begin
      x_r <= x_i;
      y_r <= y_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;

endmodule

/* src/wads_classifier.sv */
// Zone and move classification of one axis, straight from the window sum.
module wads_classifier #(
  parameter int SAMPLE_BITS   = 20,
  parameter int WINDOW_LENGTH = 1024
) (
  input  logic signed [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0] sum,
  input  logic [wads_pkg::LIMIT_BITS-1:0]                      inner,
  input  logic [wads_pkg::LIMIT_BITS-1:0]                      outer,
  output logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]        abs_sum,
  output logic                                                 neg,
  output wads_pkg::zone_t                                      zone,
  output wads_pkg::move_t                                      move
);

  localparam int LOG_L = $clog2(WINDOW_LENGTH);
  localparam int SUM_W = SAMPLE_BITS + LOG_L;
  localparam int TH_W  = wads_pkg::LIMIT_BITS + wads_pkg::FRAC_BITS + LOG_L;
  localparam int CMP_W = (SUM_W > TH_W) ? SUM_W : TH_W;
  // one integer unit of the mean, expressed in sum units
  localparam int UNIT  = WINDOW_LENGTH * (1 << wads_pkg::FRAC_BITS);

  logic [CMP_W-1:0] mag;
  logic [CMP_W-1:0] th_inner;
  logic [CMP_W-1:0] th_outer;

  // |trunc(sum/L)| >> 8 < lim  <=>  |sum| < lim * L * 256
  assign abs_sum  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign mag      = CMP_W'(abs_sum);
  assign th_inner = CMP_W'(inner) * CMP_W'(UNIT);
  assign th_outer = CMP_W'(outer) * CMP_W'(UNIT);
  assign neg      = sum[SUM_W-1];

  always_comb begin
    move = wads_pkg::MOVE_NONE;
    if (mag < th_inner) begin
      zone = wads_pkg::ZONE_INNER;
    end else if (mag < th_outer) begin
      zone = wads_pkg::ZONE_BAND;
      // no step when the integer part of the mean is zero
      if (mag >= CMP_W'(UNIT)) begin
        move = neg ? wads_pkg::MOVE_INC : wads_pkg::MOVE_DEC;
      end
    end else begin
      zone = wads_pkg::ZONE_OUTER;
    end
  end

endmodule

/* src/wads_div_cell.sv */
// Output cell: truncated window mean per axis and the zone/move control, registered.
module wads_div_cell #(
  parameter int SAMPLE_BITS   = 20,
  parameter int WINDOW_LENGTH = 1024
) (
  input  logic                                          clk,
  input  logic                                          load,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]  x_abs_i,
  input  logic [SAMPLE_BITS+$clog2(WINDOW_LENGTH)-1:0]  y_abs_i,
  input  wads_pkg::side_t                               side_i,
  output logic signed [SAMPLE_BITS-1:0]                 x_avg_o,
  output logic signed [SAMPLE_BITS-1:0]                 y_avg_o,
  output wads_pkg::side_t                               side_o
);

  localparam int LOG_L = $clog2(WINDOW_LENGTH);
  localparam int S     = SAMPLE_BITS;
  localparam int SUM_W = S + LOG_L;

  logic [S-1:0]        x_quo;
  logic [S-1:0]        y_quo;
  logic signed [S-1:0] x_avg_r;
  logic signed [S-1:0] y_avg_r;
  wads_pkg::side_t     side_r;

  // power-of-two window: the quotient of the magnitude is a shift
  assign x_quo = x_abs_i[SUM_W-1:LOG_L];
  assign y_quo = y_abs_i[SUM_W-1:LOG_L];

  // truncation toward zero: divide the magnitude, then restore the sign
  always_ff @(posedge clk) begin
    if (load) begin
      x_avg_r <= side_i.x_neg ? S'(-x_quo) : x_quo;
      y_avg_r <= side_i.y_neg ? S'(-y_quo) : y_quo;
      side_r  <= side_i;
    end
  end

  assign x_avg_o = x_avg_r;
  assign y_avg_o = y_avg_r;
  assign side_o  = side_r;

endmodule

/* src/windowed_average_deadband_stepper.sv */
// Windowed average deadband stepper: an item is accepted in every cycle while the pipeline
// has room. It goes through one register stage for the running sum and one output register
// that takes the zones and the mean, held while out_ready is low. The rate is set by the
// running-sum update, including the window clear that a nonzero Y zone triggers.
// WINDOW_LENGTH must be a power of two: the mean is the magnitude of the sum shifted right
// by log2(WINDOW_LENGTH). Each window is a shift line of WINDOW_LENGTH cells that clear
// together, so there is no clearing pass after reset. Limits are written through
// cfg_wr_en/cfg_index/cfg_wdata while idle: a user rule the block does not enforce.
module windowed_average_deadband_stepper #(
  parameter int WINDOW_LENGTH = 1024,
  parameter int SAMPLE_BITS   = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_error_x,
  input  logic signed [SAMPLE_BITS-1:0]        in_error_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_x_average,
  output logic signed [SAMPLE_BITS-1:0]        out_y_average,
  output logic [1:0]                           out_x_zone,
  output logic [1:0]                           out_y_zone,
  output logic [1:0]                           out_x_move,
  output logic [1:0]                           out_y_move,
  output logic                                 out_window_cleared,
  input  logic                                 cfg_wr_en,
  input  logic [wads_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wads_pkg::LIMIT_BITS-1:0]      cfg_wdata
);

  localparam int LOG_L = $clog2(WINDOW_LENGTH);
  localparam int S     = SAMPLE_BITS;
  localparam int SUM_W = S + LOG_L;

  // ---------------- configuration ----------------
  logic [wads_pkg::LIMIT_BITS-1:0] x_inner_r;
  logic [wads_pkg::LIMIT_BITS-1:0] x_outer_r;
  logic [wads_pkg::LIMIT_BITS-1:0] y_inner_r;
  logic [wads_pkg::LIMIT_BITS-1:0] y_outer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_inner_r <= wads_pkg::INNER_RESET;
      x_outer_r <= wads_pkg::OUTER_RESET;
      y_inner_r <= wads_pkg::INNER_RESET;
      y_outer_r <= wads_pkg::OUTER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wads_pkg::CFG_X_INNER: x_inner_r <= cfg_wdata;
        wads_pkg::CFG_X_OUTER: x_outer_r <= cfg_wdata;
        wads_pkg::CFG_Y_INNER: y_inner_r <= cfg_wdata;
        wads_pkg::CFG_Y_OUTER: y_outer_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- handshake chain ----------------
  logic s0_vld_r;
  logic out_valid_r;
  logic s0_ld;
  logic out_ld;
  logic accept;
  logic clr;
  logic fresh_r;

  assign out_ld   = !out_valid_r || out_ready;
  assign s0_ld    = !s0_vld_r || out_ld;
  assign in_ready = s0_ld;
  assign accept   = in_valid && in_ready;

  // ---------------- window shift lines ----------------
  logic signed [S-1:0] cell_x [WINDOW_LENGTH];
  logic signed [S-1:0] cell_y [WINDOW_LENGTH];

  for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_win
    if (g == 0) begin : g_head
      // a clear and a new sample at the same edge leave only the new sample
      wads_window_cell #(.SAMPLE_BITS(S)) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept),
        .zero (clr && !accept),
        .x_i  (in_error_x),
        .y_i  (in_error_y),
        .x_o  (cell_x[g]),
        .y_o  (cell_y[g])
      );
    end else begin : g_body
      wads_window_cell #(.SAMPLE_BITS(S)) u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .load (accept),
        .zero (clr),
        .x_i  (cell_x[g-1]),
        .y_i  (cell_y[g-1]),
        .x_o  (cell_x[g]),
        .y_o  (cell_y[g])
      );
    end
  end

  // ---------------- running sums ----------------
  logic signed [SUM_W-1:0] x_acc_r;
  logic signed [SUM_W-1:0] y_acc_r;
  logic signed [SUM_W-1:0] x_in_ext;
  logic signed [SUM_W-1:0] y_in_ext;
  logic signed [SUM_W-1:0] x_tail_ext;
  logic signed [SUM_W-1:0] y_tail_ext;
  logic signed [SUM_W-1:0] x_keep;
  logic signed [SUM_W-1:0] y_keep;
  logic signed [SUM_W-1:0] x_sum_nxt;
  logic signed [SUM_W-1:0] y_sum_nxt;

  assign x_in_ext   = {{LOG_L{in_error_x[S-1]}}, in_error_x};
  assign y_in_ext   = {{LOG_L{in_error_y[S-1]}}, in_error_y};
  assign x_tail_ext = {{LOG_L{cell_x[WINDOW_LENGTH-1][S-1]}}, cell_x[WINDOW_LENGTH-1]};
  assign y_tail_ext = {{LOG_L{cell_y[WINDOW_LENGTH-1][S-1]}}, cell_y[WINDOW_LENGTH-1]};
  assign x_keep     = x_acc_r + x_in_ext - x_tail_ext;
  assign y_keep     = y_acc_r + y_in_ext - y_tail_ext;

  // a pending clear counts as already applied: sum and window restart from zero
  assign x_sum_nxt = clr ? x_in_ext : x_keep;
  assign y_sum_nxt = clr ? y_in_ext : y_keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r <= '0;
      y_acc_r <= '0;
      fresh_r <= 1'b0;
    end else begin
      fresh_r <= accept;
      if (accept) begin
        x_acc_r <= x_sum_nxt;
        y_acc_r <= y_sum_nxt;
      end else if (clr) begin
        x_acc_r <= '0;
        y_acc_r <= '0;
      end
    end
  end

  // ---------------- stage 0: sum capture and zones ----------------
  logic signed [SUM_W-1:0] s0_x_sum_r;
  logic signed [SUM_W-1:0] s0_y_sum_r;
  logic [SUM_W-1:0]        s0_x_abs;
  logic [SUM_W-1:0]        s0_y_abs;
  wads_pkg::side_t         s0_side;
  wads_pkg::side_t         out_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (s0_ld) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_x_sum_r <= x_sum_nxt;
      s0_y_sum_r <= y_sum_nxt;
    end
  end

  wads_classifier #(.SAMPLE_BITS(S), .WINDOW_LENGTH(WINDOW_LENGTH)) u_x_class (
    .sum    (s0_x_sum_r),
    .inner  (x_inner_r),
    .outer  (x_outer_r),
    .abs_sum(s0_x_abs),
    .neg    (s0_side.x_neg),
    .zone   (s0_side.x_zone),
    .move   (s0_side.x_move)
  );

  wads_classifier #(.SAMPLE_BITS(S), .WINDOW_LENGTH(WINDOW_LENGTH)) u_y_class (
    .sum    (s0_y_sum_r),
    .inner  (y_inner_r),
    .outer  (y_outer_r),
    .abs_sum(s0_y_abs),
    .neg    (s0_side.y_neg),
    .zone   (s0_side.y_zone),
    .move   (s0_side.y_move)
  );

  // stage 0 holds the transaction taken at the previous edge while fresh_r is set
  assign clr = fresh_r && (s0_side.y_zone != wads_pkg::ZONE_INNER);

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= s0_vld_r;
    end
  end

  wads_div_cell #(.SAMPLE_BITS(S), .WINDOW_LENGTH(WINDOW_LENGTH)) u_div (
    .clk    (clk),
    .load   (out_ld),
    .x_abs_i(s0_x_abs),
    .y_abs_i(s0_y_abs),
    .side_i (s0_side),
    .x_avg_o(out_x_average),
    .y_avg_o(out_y_average),
    .side_o (out_side)
  );

  assign out_valid          = out_valid_r;
  assign out_x_zone         = out_side.x_zone;
  assign out_y_zone         = out_side.y_zone;
  assign out_x_move         = out_side.x_move;
  assign out_y_move         = out_side.y_move;
  assign out_window_cleared = (out_side.y_zone != wads_pkg::ZONE_INNER);

`ifndef NO_ASSERTIONS
  a_clear_zeroes_sums: assert property (@(posedge clk) disable iff (!rst_n)
    clr && !accept |=> x_acc_r == '0 && y_acc_r == '0)
    else $error("running sums not cleared");

  a_clear_zeroes_tail: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> cell_x[WINDOW_LENGTH-1] == '0 && cell_y[WINDOW_LENGTH-1] == '0)
    else $error("window tail not cleared");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_x_average)
      && $stable(out_y_average))
    else $error("result changed while waiting");

  a_move_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_side.x_move != wads_pkg::MOVE_NONE
      |-> out_side.x_zone == wads_pkg::ZONE_BAND)
    else $error("X move requested outside correction band");
`endif

endmodule
